### rtl/cspb_pkg.sv
`default_nettype none

package cspb_pkg;

  // Framebuffer geometry
  localparam int unsigned FRAME_ADDR_BITS = 17;
  localparam int unsigned COORD_W         = 10;
  localparam int unsigned SPRITE_W        = 9;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned TIDX_W          = 16;
  localparam int unsigned PROD_W          = 2 * COORD_W;
  localparam int unsigned ADDR_FULL_W     = PROD_W + 1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd352;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd216;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_BLEND  = 2'd2
  } mode_e;

  // One item after address generation
  typedef struct packed {
    logic                       valid;
    cmd_e                       cmd;
    mode_e                      mode;
    logic [PIX_W-1:0]           pix;
    logic [TIDX_W-1:0]          tidx;
    logic                       ok;
    logic [FRAME_ADDR_BITS-1:0] addr;
  } item_t;

endpackage

`default_nettype wire

### rtl/cspb_locate.sv
`default_nettype none

module cspb_locate import cspb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire cmd_e                cmd_i,
  input  wire mode_e               mode_i,
  input  wire logic [COORD_W-1:0]  origin_x_i,
  input  wire logic [COORD_W-1:0]  origin_y_i,
  input  wire logic [SPRITE_W-1:0] col_i,
  input  wire logic [SPRITE_W-1:0] row_i,
  input  wire logic [PIX_W-1:0]    pixel_i,
  input  wire logic [TIDX_W-1:0]   table_index_i,
  input  wire logic [COORD_W-1:0]  frame_width_i,
  input  wire logic [COORD_W-1:0]  frame_height_i,
  output item_t                    item_o
);

  // Stage 1: target point
  logic                  v1_q;
  cmd_e                  cmd1_q;
  mode_e                 mode1_q;
  logic [PIX_W-1:0]      pix1_q;
  logic [TIDX_W-1:0]     tidx1_q;
  logic [COORD_W:0]      px1_q, py1_q;
  logic [COORD_W:0]      px1_d, py1_d;
  logic [SPRITE_W-1:0]   cx, cy;

  // Stage 2: clip flag and row offset
  logic                  v2_q;
  cmd_e                  cmd2_q;
  mode_e                 mode2_q;
  logic [PIX_W-1:0]      pix2_q;
  logic [TIDX_W-1:0]     tidx2_q;
  logic [COORD_W-1:0]    px2_q;
  logic                  in_frame2_q, in_frame2_d;
  logic [PROD_W-1:0]     prod2_q, prod2_d;
  logic [ADDR_FULL_W-1:0] addr_full;

  // Read commands address the origin itself
  always_comb begin
    cx = (cmd_i == CMD_READ) ? '0 : col_i;
    cy = (cmd_i == CMD_READ) ? '0 : row_i;
    px1_d = {origin_x_i[COORD_W-1], origin_x_i} + {2'b00, cx};
    py1_d = {origin_y_i[COORD_W-1], origin_y_i} + {2'b00, cy};
  end

  // Clip against the frame and form the row base
  always_comb begin
    in_frame2_d = !px1_q[COORD_W] && !py1_q[COORD_W]
                  && (px1_q[COORD_W-1:0] < frame_width_i)
                  && (py1_q[COORD_W-1:0] < frame_height_i);
    prod2_d = py1_q[COORD_W-1:0] * frame_width_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q      <= cmd_i;
      mode1_q     <= mode_i;
      pix1_q      <= pixel_i;
      tidx1_q     <= table_index_i;
      px1_q       <= px1_d;
      py1_q       <= py1_d;
      cmd2_q      <= cmd1_q;
      mode2_q     <= mode1_q;
      pix2_q      <= pix1_q;
      tidx2_q     <= tidx1_q;
      px2_q       <= px1_q[COORD_W-1:0];
      in_frame2_q <= in_frame2_d;
      prod2_q     <= prod2_d;
    end
  end

  // Linear address and memory bound check
  assign addr_full = {1'b0, prod2_q} + {{(ADDR_FULL_W-COORD_W){1'b0}}, px2_q};

  always_comb begin
    item_o.valid = v2_q;
    item_o.cmd   = cmd2_q;
    item_o.mode  = mode2_q;
    item_o.pix   = pix2_q;
    item_o.tidx  = tidx2_q;
    item_o.ok    = in_frame2_q && (addr_full[ADDR_FULL_W-1:FRAME_ADDR_BITS] == '0);
    item_o.addr  = addr_full[FRAME_ADDR_BITS-1:0];
  end

endmodule

`default_nettype wire

### rtl/cspb_frame.sv
`default_nettype none

module cspb_frame import cspb_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic [FRAME_ADDR_BITS-1:0] rd_addr_i,
  input  wire logic [FRAME_ADDR_BITS-1:0] cur_addr_i,
  input  wire logic                       wr_en_i,
  input  wire logic [FRAME_ADDR_BITS-1:0] wr_addr_i,
  input  wire logic [PIX_W-1:0]           wr_data_i,
  output logic      [PIX_W-1:0]           dst_o
);

  localparam int unsigned DEPTH = 1 << FRAME_ADDR_BITS;

  logic [PIX_W-1:0]           mem [DEPTH];
  logic [PIX_W-1:0]           rdata_q;
  logic                       lw_valid_q;
  logic [FRAME_ADDR_BITS-1:0] lw_addr_q;
  logic [PIX_W-1:0]           lw_data_q;

  // Read-first port: a write on the read edge is caught by the last-write register
  always_ff @(posedge clk_i) begin
    if (en_i && wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Track the write that landed on the read edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (en_i) begin
      lw_valid_q <= wr_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lw_addr_q <= wr_addr_i;
      lw_data_q <= wr_data_i;
    end
  end

  // Forward the newest pending write to the same pixel
  always_comb begin
    if (wr_en_i && (wr_addr_i == cur_addr_i)) begin
      dst_o = wr_data_i;
    end else if (lw_valid_q && (lw_addr_q == cur_addr_i)) begin
      dst_o = lw_data_q;
    end else begin
      dst_o = rdata_q;
    end
  end

endmodule

`default_nettype wire

### rtl/cspb_blend.sv
`default_nettype none

module cspb_blend import cspb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              wr_en_i,
  input  wire logic [TIDX_W-1:0] wr_addr_i,
  input  wire logic [PIX_W-1:0]  wr_data_i,
  input  wire logic [TIDX_W-1:0] rd_addr_i,
  output logic      [PIX_W-1:0]  rd_data_o
);

  localparam int unsigned DEPTH = 1 << TIDX_W;

  logic [PIX_W-1:0] mem [DEPTH];

  // Load entries and read one entry per advance, read-first
  always_ff @(posedge clk_i) begin
    if (en_i && wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/clipped_sprite_pixel_blitter.sv
// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid/s_axis_tready    tdata[71:0] draw, load or read item
// m_axis      out  m_axis_tvalid/m_axis_tready    tdata[15:0] result item
// cfg         in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One item per clock while the skid entry is free; results come from a register.
// The pipeline is frame read -> forward -> blend read -> frame write, sharing one
// read and one write port on each memory, with forwarding between pixel updates.
// Reset clears valid flags and loads width 352, height 216; memories are not cleared.
// A stalled output fills the output register, then one skid entry, then holds s_axis.
`default_nettype none

module clipped_sprite_pixel_blitter import cspb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cmd, mode, origin_x, origin_y, col, row, pixel, table_index, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // read_pixel, wrote, clipped, zero pad
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [COORD_W-1:0]    cfg_data_i
);

  logic                 en;
  logic [COORD_W-1:0]   width_q, height_q;
  item_t                s2, s3_q, s4_q;
  logic [PIX_W-1:0]     dst3;
  logic [PIX_W-1:0]     dst4_q;
  logic [PIX_W-1:0]     blend_rd;
  logic                 we4;
  logic [PIX_W-1:0]     wdata4;
  logic [9:0]           res;
  logic                 push;
  logic                 out_free;
  logic                 out_valid_q, out_valid_d;
  logic [9:0]           out_data_q, out_data_d;
  logic                 skid_valid_q, skid_valid_d;
  logic [9:0]           skid_data_q, skid_data_d;

  // Advance the whole pipeline while the skid entry is free
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  cspb_locate u_locate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .cmd_i         (cmd_e'(s_axis_tdata[1:0])),
    .mode_i        (mode_e'(s_axis_tdata[3:2])),
    .origin_x_i    (s_axis_tdata[13:4]),
    .origin_y_i    (s_axis_tdata[23:14]),
    .col_i         (s_axis_tdata[32:24]),
    .row_i         (s_axis_tdata[41:33]),
    .pixel_i       (s_axis_tdata[49:42]),
    .table_index_i (s_axis_tdata[65:50]),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .item_o        (s2)
  );

  // Stage registers after the frame read and after the blend read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q   <= '0;
      s4_q   <= '0;
      dst4_q <= '0;
    end else if (en) begin
      s3_q   <= s2;
      s4_q   <= s3_q;
      dst4_q <= dst3;
    end
  end

  cspb_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .rd_addr_i (s2.addr),
    .cur_addr_i(s3_q.addr),
    .wr_en_i   (we4),
    .wr_addr_i (s4_q.addr),
    .wr_data_i (wdata4),
    .dst_o     (dst3)
  );

  // Load blend entries in stage 2, look up {src, dst} in stage 3
  cspb_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (en),
    .wr_en_i  (s2.valid && (s2.cmd == CMD_LOAD)),
    .wr_addr_i(s2.tidx),
    .wr_data_i(s2.pix),
    .rd_addr_i({s3_q.pix, dst3}),
    .rd_data_o(blend_rd)
  );

  // Decide the frame write and build the result
  always_comb begin
    we4 = 1'b0;
    if (s4_q.valid && (s4_q.cmd == CMD_DRAW) && s4_q.ok) begin
      case (s4_q.mode)
        MODE_OPAQUE: we4 = 1'b1;
        MODE_KEY:    we4 = (s4_q.pix != '0);
        MODE_BLEND:  we4 = (s4_q.pix != '0);
        default:     we4 = 1'b0;
      endcase
    end
    wdata4 = (s4_q.mode == MODE_BLEND) ? blend_rd : s4_q.pix;
    res = '0;
    case (s4_q.cmd)
      CMD_DRAW: res = {{PIX_W{1'b0}}, we4, !s4_q.ok};
      CMD_READ: res = {(s4_q.ok ? dst4_q : {PIX_W{1'b0}}), 1'b0, !s4_q.ok};
      default:  res = '0;
    endcase
  end

  // Output register with one skid entry
  assign push     = en && s4_q.valid;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = res;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  // Result fields from the low bit: read_pixel, wrote, clipped
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q[0], out_data_q[1], out_data_q[9:2]};

endmodule

`default_nettype wire

### tb/clipped_sprite_pixel_blitter_tb.sv
module clipped_sprite_pixel_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cspb_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int N_SIZES        = 10;
  localparam int ITEMS_PER_SIZE = 115;
  localparam int SIZE_W [N_SIZES] = '{1, 512, 16, 0, 7, 1023, 512, 3, 40, 352};
  localparam int SIZE_H [N_SIZES] = '{1, 512, 8, 5, 0, 1023, 1, 512, 30, 216};
  localparam logic [7:0] PALETTE [6] = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h5A, 8'hC3};

  typedef struct {
    logic [1:0]                 cmd;
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  ox;
    logic signed [COORD_W-1:0]  oy;
    logic [SPRITE_W-1:0]        col;
    logic [SPRITE_W-1:0]        row;
    logic [PIX_W-1:0]           pix;
    logic [TIDX_W-1:0]          tidx;
  } blit_item_t;

  typedef struct packed {
    logic             clipped;
    logic             wrote;
    logic [PIX_W-1:0] read_pixel;
  } blit_result_t;

  // Shadow copy of framebuffer and blend table, plus the results still due
  class blit_shadow;
    logic [7:0]   frame_mem [int unsigned];
    logic [7:0]   blend_mem [int unsigned];
    int           width;
    int           height;
    blit_result_t due [$];
    int           errors;
    int           n_checked;
    int           n_wrote;
    int           n_clipped;
    int           n_reads;

    function new();
      width  = WIDTH_RESET;
      height = HEIGHT_RESET;
    endfunction

    // Map a point to a framebuffer address; returns 0 when it falls outside frame or memory
    function bit locate(int px, int py, output int unsigned addr);
      addr = 0;
      if (px < 0 || py < 0) return 1'b0;
      if (px >= width || py >= height) return 1'b0;
      addr = py * width + px;
      if (addr >= (1 << FRAME_ADDR_BITS)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) width = val;
      else if (idx == CFG_FRAME_HEIGHT) height = val;
    endfunction

    // Apply one accepted item to the shadow state and queue its result
    function void note_item(blit_item_t it);
      blit_result_t r;
      int unsigned  a;
      int           px;
      int           py;
      r  = '0;
      px = it.ox;
      py = it.oy;
      if (it.cmd == CMD_DRAW) begin
        px = px + int'(it.col);
        py = py + int'(it.row);
        if (!locate(px, py, a)) begin
          r.clipped = 1'b1;
        end else if (it.mode == MODE_OPAQUE || (it.mode == MODE_KEY && it.pix != 0)) begin
          frame_mem[a] = it.pix;
          r.wrote = 1'b1;
        end else if (it.mode == MODE_BLEND && it.pix != 0) begin
          frame_mem[a] = blend_mem[{it.pix, frame_mem[a]}];
          r.wrote = 1'b1;
        end
      end else if (it.cmd == CMD_LOAD) begin
        blend_mem[it.tidx] = it.pix;
      end else if (it.cmd == CMD_READ) begin
        if (locate(px, py, a)) begin
          r.read_pixel = frame_mem[a];
          n_reads++;
        end else begin
          r.clipped = 1'b1;
        end
      end
      if (r.wrote) n_wrote++;
      if (r.clipped) n_clipped++;
      due.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 20) $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      blit_result_t want;
      n_checked++;
      if (due.size() == 0) begin
        report("result with nothing due", data, '0);
        return;
      end
      want = due.pop_front();
      if (data[7:0] !== want.read_pixel) report("read_pixel", data[7:0], want.read_pixel);
      if (data[8] !== want.wrote) report("wrote", data[8], want.wrote);
      if (data[9] !== want.clipped) report("clipped", data[9], want.clipped);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [COORD_W-1:0]    cfg_data_i;

  blit_shadow shadow = new();
  bit         src_idle_on;
  bit         sink_idle_on;
  bit         long_hold_req;
  int         items_sent;

  clipped_sprite_pixel_blitter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Check every result item taken by the sink
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) shadow.check_result(m_axis_tdata);
  end

  // Sink: random stall bursts, plus one long hold-off on request
  initial begin
    int sink_hold;
    sink_hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_hold = 64;
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        sink_hold = $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results still due", shadow.due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(blit_item_t it);
    return {{(IN_DATA_W - 66){1'b0}}, it.tidx, it.pix, it.row, it.col,
            it.oy, it.ox, it.mode, it.cmd};
  endfunction

  function automatic logic [7:0] pick_pixel();
    return ($urandom_range(0, 9) < 7) ? PALETTE[$urandom_range(0, 5)] : 8'($urandom);
  endfunction

  function automatic blit_item_t mk(logic [1:0] cmd, logic [1:0] mode, int ox, int oy,
                                    int col, int row, int pix, int tidx);
    blit_item_t it;
    it.cmd  = cmd;
    it.mode = mode;
    it.ox   = 10'(ox);
    it.oy   = 10'(oy);
    it.col  = 9'(col);
    it.row  = 9'(row);
    it.pix  = 8'(pix);
    it.tidx = 16'(tidx);
    return it;
  endfunction

  // Random item, mostly draws aimed into the frame and often at a tiny hot spot
  function automatic blit_item_t rand_item();
    blit_item_t it;
    int         k;
    int         tx;
    int         ty;
    int         c;
    it = mk(CMD_DRAW, 2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom,
            pick_pixel(), $urandom);
    k  = $urandom_range(0, 99);
    if (k < 55) begin
      if (shadow.width > 0 && shadow.height > 0) begin
        tx = $urandom_range(0, shadow.width - 1);
        ty = $urandom_range(0, shadow.height - 1);
        if ($urandom_range(0, 2) != 0) begin
          tx = tx % 4;
          ty = ty % 2;
        end
        c = $urandom_range(tx > 511 ? tx - 511 : 0, 511);
        it.col = 9'(c);
        it.ox  = 10'(tx - c);
        c = $urandom_range(ty > 511 ? ty - 511 : 0, 511);
        it.row = 9'(c);
        it.oy  = 10'(ty - c);
      end
      if ($urandom_range(0, 9) < 4) it.mode = MODE_BLEND;
    end else if (k < 65) begin
      it.mode = 2'($urandom);
      it.pix  = 8'($urandom);
    end else if (k < 80) begin
      it.cmd = CMD_READ;
      if (shadow.width > 0 && shadow.height > 0 && $urandom_range(0, 4) != 0) begin
        tx = $urandom_range(0, (shadow.width > 512 ? 512 : shadow.width) - 1);
        ty = $urandom_range(0, (shadow.height > 512 ? 512 : shadow.height) - 1);
        if ($urandom_range(0, 1) != 0) begin
          tx = tx % 4;
          ty = ty % 2;
        end
        it.ox = 10'(tx);
        it.oy = 10'(ty);
      end
    end else if (k < 90) begin
      it.cmd = CMD_LOAD;
      it.pix = 8'($urandom);
    end else if (k < 95) begin
      it.mode = MODE_NONE;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  // Offer one item until taken, then maybe leave a gap
  task automatic send_raw(blit_item_t it);
    s_axis_tdata  <= pack_item(it);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    shadow.note_item(it);
    items_sent++;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Send an item, first writing any pixel or blend entry it would read
  task automatic send_item(blit_item_t it);
    int unsigned a;
    blit_item_t  pre;
    int          px;
    int          py;
    px = it.ox;
    py = it.oy;
    if (it.cmd == CMD_DRAW && it.mode == MODE_BLEND && it.pix != 0 &&
        shadow.locate(px + int'(it.col), py + int'(it.row), a)) begin
      if (!shadow.frame_mem.exists(a)) begin
        pre      = it;
        pre.mode = MODE_OPAQUE;
        pre.pix  = pick_pixel();
        send_raw(pre);
      end
      if (!shadow.blend_mem.exists({it.pix, shadow.frame_mem[a]}))
        send_raw(mk(CMD_LOAD, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                    pick_pixel(), {it.pix, shadow.frame_mem[a]}));
    end
    if (it.cmd == CMD_READ && shadow.locate(px, py, a) && !shadow.frame_mem.exists(a))
      send_raw(mk(CMD_DRAW, MODE_OPAQUE, px, py, 0, 0, pick_pixel(), $urandom));
    send_raw(it);
  endtask

  // Stop offering and wait until every due result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shadow.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_FRAME_WIDTH;
    cfg_data_i    <= '0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed items at the reset frame size of 352 x 216
    send_item(mk(CMD_DRAW, MODE_OPAQUE, 0, 0, 0, 0, 'hA5, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_DRAW, MODE_OPAQUE, 300, 200, 51, 15, 'hFF, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 351, 215, 0, 0, 0, 0));
    send_item(mk(CMD_DRAW, MODE_OPAQUE, 511, 511, 511, 511, 'h5A, 'hFFFF));
    send_item(mk(CMD_DRAW, MODE_KEY, -512, -512, 0, 0, 'h11, 0));
    send_item(mk(CMD_DRAW, MODE_OPAQUE, -512, 100, 511, 0, 'h22, 0));
    send_item(mk(CMD_DRAW, MODE_OPAQUE, 100, -512, 0, 511, 'h22, 0));
    send_item(mk(CMD_DRAW, MODE_KEY, -5, -1, 7, 1, 'h00, 0));
    send_item(mk(CMD_DRAW, MODE_KEY, -5, -1, 5, 1, 'h3C, 0));
    send_item(mk(CMD_LOAD, MODE_OPAQUE, 0, 0, 0, 0, 'h77, 'h813C));
    send_item(mk(CMD_DRAW, MODE_BLEND, 0, 0, 0, 0, 'h81, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_DRAW, MODE_BLEND, 0, 0, 0, 0, 'h00, 0));
    send_item(mk(CMD_DRAW, MODE_NONE, 0, 0, 0, 0, 'h12, 0));
    send_item(mk(CMD_DRAW, MODE_NONE, 352, 0, 0, 0, 'h12, 0));
    send_item(mk(CMD_NONE, MODE_NONE, -1, -1, 511, 511, 'hFF, 'hFFFF));
    send_item(mk(CMD_LOAD, MODE_NONE, -1, -1, 511, 511, 'hFF, 'hFFFF));
    send_item(mk(CMD_LOAD, MODE_OPAQUE, 0, 0, 0, 0, 'h00, 'h0000));
    send_item(mk(CMD_READ, MODE_OPAQUE, -1, 0, 0, 0, 0, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 352, 0, 0, 0, 0, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 0, 216, 0, 0, 0, 0));
    // Successive updates of one pixel, then a readback of it
    send_item(mk(CMD_LOAD, MODE_OPAQUE, 0, 0, 0, 0, 'h42, 'h2010));
    send_item(mk(CMD_DRAW, MODE_OPAQUE, 5, 5, 0, 0, 'h10, 0));
    send_item(mk(CMD_DRAW, MODE_BLEND, 3, 4, 2, 1, 'h20, 0));
    send_item(mk(CMD_READ, MODE_OPAQUE, 5, 5, 0, 0, 0, 0));

    // Random items over a series of frame sizes, last ones without idling
    for (int p = 0; p < N_SIZES; p++) begin
      drain();
      cfg_index_i <= CFG_FRAME_WIDTH;
      cfg_data_i  <= 10'(SIZE_W[p]);
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      shadow.note_config(CFG_FRAME_WIDTH, 10'(SIZE_W[p]));
      cfg_index_i <= CFG_FRAME_HEIGHT;
      cfg_data_i  <= 10'(SIZE_H[p]);
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      shadow.note_config(CFG_FRAME_HEIGHT, 10'(SIZE_H[p]));
      cfg_valid_i <= 1'b0;

      src_idle_on  = (p < N_SIZES - 2) && (p % 3 != 1);
      sink_idle_on = (p < N_SIZES - 2) && (p % 3 != 2);

      // Hold the sink off while items keep coming, so the input backs up
      if (p == 2) begin
        src_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_item(rand_item());
        src_idle_on   = 1'b1;
      end

      for (int i = 0; i < ITEMS_PER_SIZE; i++) begin
        send_item(rand_item());
        if (i == ITEMS_PER_SIZE / 2 && p % 2 == 0) drain();
      end
    end

    drain();
    $display("Ran %0d items over %0d frame sizes (zero, single pixel, 1023 x 1023 included)",
             items_sent, N_SIZES);
    $display("Checked %0d results: %0d pixel writes, %0d clipped, %0d readbacks",
             shadow.n_checked, shadow.n_wrote, shadow.n_clipped, shadow.n_reads);
    if (shadow.errors == 0 && shadow.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
